// ===== src/des_key_schedule_top_defines.svh =====
`ifndef DES_KEY_SCHEDULE_TOP_DEFINES_SVH
`define DES_KEY_SCHEDULE_TOP_DEFINES_SVH

// same-cycle implication, checked at every clock edge outside reset
`define DES_KS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("des key schedule: same-cycle check failed");

// next-cycle implication, checked at every clock edge outside reset
`define DES_KS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("des key schedule: next-cycle check failed");

`endif

// ===== src/des_ks_pkg.sv =====
`timescale 1ns / 1ps

package des_ks_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CD_W    = 56;
  localparam int unsigned HALF_W  = 28;
  localparam int unsigned SUBKEY_W = 48;
  localparam int unsigned ROUND_W = 4;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

  // bit r set where round r rotates by two places, clear where by one
  localparam logic [15:0] ROT_TWO = 16'h7CFC;

  // key permutation that drops the parity bits, entries numbered from 1 at the msb of the key
  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // subkey bit selection, entries numbered from 1 at the msb of c:d
  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] r;
    logic [5:0]      pos;
    r = '0;
    for (int i = 0; i < 56; i++) begin
      pos = 6'(7'd64 - PC1_TAB[i]);
      r[CD_W-1-i] = key[pos];
    end
    return r;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] r;
    logic [5:0]          pos;
    r = '0;
    for (int i = 0; i < 48; i++) begin
      pos = 6'd56 - PC2_TAB[i];
      r[SUBKEY_W-1-i] = cd[pos];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] v,
                                               input logic two);
    return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
               : {v[HALF_W-2:0], v[HALF_W-1]};
  endfunction

endpackage

// ===== src/des_ks_round.sv =====
`timescale 1ns / 1ps

module des_ks_round
  import des_ks_pkg::*;
(
  input  logic [HALF_W-1:0]   c,
  input  logic [HALF_W-1:0]   d,
  input  logic                two_shift,
  output logic [HALF_W-1:0]   c_rot,
  output logic [HALF_W-1:0]   d_rot,
  output logic [SUBKEY_W-1:0] subkey
);

  assign c_rot  = rotl28(c, two_shift);
  assign d_rot  = rotl28(d, two_shift);
  assign subkey = pc2({c_rot, d_rot});

endmodule

// ===== src/des_key_schedule_top.sv =====
`timescale 1ns / 1ps

// Key schedule with DES PC-1 and PC-2: each key accepted on the input channel
// yields its sixteen 48-bit round subkeys, one per transaction on the output
// channel, round 0 first, with last_key set on round 15. Parity bits of the key
// are ignored. One rotate and PC-2 stage is stepped once per round by a 4-bit
// round counter, so one subkey leaves per cycle while the output is not stalled.
// The first subkey reaches the output register after the key halves are loaded
// into c and d and the output is ready, and the next key is taken in the cycle
// that the sixteenth subkey is produced, so back-to-back keys stream with no gap.
module des_key_schedule_top
  import des_ks_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    key_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ROUND_W-1:0]  round_index,
  output logic [SUBKEY_W-1:0] round_key,
  output logic                last_key
);

  logic                busy;
  logic [ROUND_W-1:0]  round;
  logic [HALF_W-1:0]   c;
  logic [HALF_W-1:0]   d;
  logic [HALF_W-1:0]   c_rot;
  logic [HALF_W-1:0]   d_rot;
  logic [SUBKEY_W-1:0] subkey;
  logic [CD_W-1:0]     key56;
  logic                out_ready;
  logic                gen_fire;
  logic                run_end;
  logic                in_take;

  assign key56     = pc1(key_in);
  assign out_ready = !out_valid || !out_stall;
  assign gen_fire  = busy && out_ready;
  assign run_end   = gen_fire && (round == LAST_ROUND);
  assign in_stall  = busy && !run_end;
  assign in_take   = in_valid && !in_stall;

  des_ks_round u_round (
    .c         (c),
    .d         (d),
    .two_shift (ROT_TWO[round]),
    .c_rot     (c_rot),
    .d_rot     (d_rot),
    .subkey    (subkey)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
    end else if (in_take) begin
      busy  <= 1'b1;
      round <= '0;
    end else if (run_end) begin
      busy  <= 1'b0;
    end else if (gen_fire) begin
      round <= round + 1'b1;
    end
  end

  // c and d hold the halves already rotated up to the current round
  always_ff @(posedge clk) begin
    if (in_take) begin
      c <= key56[CD_W-1:HALF_W];
      d <= key56[HALF_W-1:0];
    end else if (gen_fire) begin
      c <= c_rot;
      d <= d_rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      round_index <= round;
      round_key   <= subkey;
      last_key    <= (round == LAST_ROUND);
    end
  end

endmodule

// ===== src/des_ks_checker.sv =====
`timescale 1ns / 1ps
`include "des_key_schedule_top_defines.svh"

module des_ks_checker
  import des_ks_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ROUND_W-1:0]  round_index,
  input logic [SUBKEY_W-1:0] round_key,
  input logic                last_key
);

  // flag marks exactly the final round
  `DES_KS_ASSERT_NOW(a_last_flag, out_valid, last_key == (round_index == LAST_ROUND))

  // within a run the subkeys follow without gaps, round by round
  `DES_KS_ASSERT_NEXT(a_round_step, out_valid && !out_stall && !last_key, out_valid && (round_index == $past(round_index) + 1'b1))

  // no new key while more than one subkey of the run is still to come
  `DES_KS_ASSERT_NOW(a_key_held_off, out_valid && (round_index < LAST_ROUND - 1'b1), in_stall)

  // a stalled transaction keeps its payload
  `DES_KS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(round_key) && $stable(round_index) && $stable(last_key))

endmodule

bind des_key_schedule_top des_ks_checker u_des_ks_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .round_index (round_index),
  .round_key   (round_key),
  .last_key    (last_key)
);
